// ----- hdl/tpdf_dither_quantizer_assert.svh -----
// ============================================================================
// Assertion macros for the TPDF dither quantizer
// Shared concurrent assertion helpers. Simulation builds get the checks;
// synthesis builds get empty bodies.
// ============================================================================
`ifndef TPDF_DITHER_QUANTIZER_ASSERT_SVH
`define TPDF_DITHER_QUANTIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tdq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tdq assertion failed");

`else

`define TDQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TDQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/tdq_pkg.sv -----
// ============================================================================
// tdq_pkg
// Types, constants and the xorshift step shared by the quantizer modules.
// ============================================================================
package tdq_pkg;

    // Field widths fixed by the stream format.
    localparam int SAMPLE_W = 25;
    localparam int DSUM_W   = 17;
    localparam int CODE_W   = 16;

    // Dither generator seed loaded at reset and at each image start.
    localparam logic [31:0] SEED_INIT = 32'h9E37_79B9;

    // Output mode register codes.
    typedef enum logic {
        MODE_DITHER8 = 1'b0,
        MODE_ROUND16 = 1'b1
    } mode_t;

    // One sample on its way from the input register to the quantizer.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [DSUM_W-1:0]   dither_sum;
        mode_t               mode;
    } item_t;

    // One 32-bit xorshift step (shifts 13, 17, 5).
    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

// ----- hdl/tdq_xorshift.sv -----
// ============================================================================
// tdq_xorshift
// Dither generator: holds the xorshift seed, runs two steps per dithered
// sample and returns the sum of the two low 16-bit halves.
// ============================================================================
`include "tpdf_dither_quantizer_assert.svh"

module tdq_xorshift
    import tdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              reload,
    input  logic              advance,
    output logic [DSUM_W-1:0] dither_sum
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] seed_base;
    logic [31:0] step_a;
    logic [31:0] step_b;

    // Two generator steps from the current or the reloaded seed.
    always_comb
    begin
        seed_base  = reload ? SEED_INIT : seed_reg;
        step_a     = xs_step(seed_base);
        step_b     = xs_step(step_a);
        dither_sum = {1'b0, step_a[15:0]} + {1'b0, step_b[15:0]};
    end

    // The seed moves only on dithered samples; a reload still lands in plain mode.
    always_comb
    begin
        if (advance)
        begin
            seed_next = step_b;
        end
        else
        begin
            seed_next = seed_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_INIT;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    // A reload followed by two steps always gives the same seed.
    `TDQ_ASSERT_NXT(a_reload_seed, clk, rst_n, reload && advance,
                    seed_reg == xs_step(xs_step(SEED_INIT)))
    // Without a dithered sample or a reload the seed holds.
    `TDQ_ASSERT_NXT(a_seed_holds, clk, rst_n, !reload && !advance, $stable(seed_reg))
    // A dithered sample always changes the seed.
    `TDQ_ASSERT_NXT(a_seed_moves, clk, rst_n, advance && !reload,
                    seed_reg == xs_step(xs_step($past(seed_reg))))

endmodule

// ----- hdl/tdq_quantize.sv -----
// ============================================================================
// tdq_quantize
// Combinational quantizer: dithered 8-bit code or rounded 16-bit code from
// one registered sample.
// ============================================================================
module tdq_quantize
    import tdq_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  item_t             item,
    output logic [CODE_W-1:0] code
);

    // Sample bits above bit FRAC_BITS are ignored.
    localparam int VW = (FRAC_BITS + 1 < SAMPLE_W) ? FRAC_BITS + 1 : SAMPLE_W;
    // Dithered sum stays below 2^(FRAC_BITS+10); rounded 16-bit sum below 2^(FRAC_BITS+17).
    localparam int MW = FRAC_BITS + 10;
    localparam int RW = FRAC_BITS + 17;
    localparam int QW = MW - FRAC_BITS;
    localparam int HW = RW - FRAC_BITS;

    logic [VW-1:0]     v;
    logic [MW-1:0]     v_m;
    logic [MW-1:0]     sum_m;
    logic [QW-1:0]     q;
    logic [QW-1:0]     q_minus;
    logic [7:0]        code8;
    logic [RW-1:0]     v_r;
    logic [RW-1:0]     sum_r;
    logic [HW-1:0]     r_hi;
    logic [CODE_W-1:0] code16;

    // 8-bit path: v*255 + dither (offset by one code) + half, then clamp.
    always_comb
    begin
        v       = item.sample[VW-1:0];
        v_m     = MW'(v);
        sum_m   = (v_m << 8) - v_m
                + (MW'(item.dither_sum) << (FRAC_BITS - 16))
                + (MW'(1) << (FRAC_BITS - 1));
        q       = sum_m[MW-1:FRAC_BITS];
        q_minus = q - QW'(1);
        if (q == '0)
        begin
            code8 = 8'd0;
        end
        else if (q_minus > QW'(255))
        begin
            code8 = 8'd255;
        end
        else
        begin
            code8 = q_minus[7:0];
        end
    end

    // 16-bit path: v*65535 + half, then saturate.
    always_comb
    begin
        v_r    = RW'(v);
        sum_r  = (v_r << 16) - v_r + (RW'(1) << (FRAC_BITS - 1));
        r_hi   = sum_r[RW-1:FRAC_BITS];
        code16 = (r_hi > HW'(16'hFFFF)) ? 16'hFFFF : r_hi[CODE_W-1:0];
    end

    always_comb
    begin
        unique case (item.mode)
            MODE_DITHER8: code = {8'd0, code8};
            MODE_ROUND16: code = code16;
            default:      code = code16;
        endcase
    end

endmodule

// ----- hdl/tpdf_dither_quantizer.sv -----
// ============================================================================
// tpdf_dither_quantizer
// Quantizes 0..1 colour samples to 8-bit codes with triangular dither or to
// rounded 16-bit codes.
// ============================================================================
//  Channel   Dir  Fields (low bit first)
//  s_*       in   tdata: sample_value[24:0], zero pad; tuser: image_start
//  m_*       out  tdata: code_value[15:0]
//  cfg_*     in   cfg_wr_data: output_mode (0 = dithered 8-bit, 1 = 16-bit)
//
//  One beat per clock in each direction while the receiver holds m_tready high;
//  a result passes the input register, then the result register.
//  The seed update is a two-step XOR network done at input acceptance.
//  Reset clears the valid flags, the mode and loads the dither seed.
//  A stalled result register holds; the input register accepts while it is empty
//  or while the result register is free or being emptied in the same cycle.
// ============================================================================
`include "tpdf_dither_quantizer_assert.svh"

module tpdf_dither_quantizer
    import tdq_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,      // output_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,          // sample_value[24:0], zero pad [31:25]
    input  logic        s_tuser,          // image_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata           // code_value[15:0]
);

    mode_t             mode_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    item_t             s1_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              s_accept;
    logic              out_free;
    logic              s1_move;
    logic [DSUM_W-1:0] dither_sum;
    logic [CODE_W-1:0] quant_code;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DITHER8;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    // Handshake: the pipeline advances whenever the result register is free.
    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        s1_move        = s1_valid_reg && out_free;
        s_tready       = !s1_valid_reg || out_free;
        s_accept       = s_tvalid && s_tready;
        s1_valid_next  = s_accept || (s1_valid_reg && !out_free);
        out_valid_next = s1_move || (out_valid_reg && !m_tready);
    end

    // Dither generator, stepped at input acceptance of dithered samples.
    tdq_xorshift u_xorshift (
        .clk        (clk),
        .rst_n      (rst_n),
        .reload     (s_accept && s_tuser),
        .advance    (s_accept && (mode_reg == MODE_DITHER8)),
        .dither_sum (dither_sum)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg.sample     <= s_tdata[SAMPLE_W-1:0];
            s1_item_reg.dither_sum <= dither_sum;
            s1_item_reg.mode       <= mode_reg;
        end
    end

    tdq_quantize #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quantize (
        .item (s1_item_reg),
        .code (quant_code)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_code_reg <= quant_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;

    // An accepted beat always lands in the input register.
    `TDQ_ASSERT_NXT(a_accept_lands, clk, rst_n, s_accept, s1_valid_reg)
    // A held sample is not dropped while the result register is blocked.
    `TDQ_ASSERT_NXT(a_s1_holds, clk, rst_n, s1_valid_reg && !out_free,
                    s1_valid_reg && $stable(s1_item_reg))
    // Dithered codes never exceed eight bits.
    `TDQ_ASSERT_IMP(a_code8_range, clk, rst_n,
                    s1_valid_reg && (s1_item_reg.mode == MODE_DITHER8),
                    quant_code[15:8] == 8'd0)
    // A moved sample always produces a result beat.
    `TDQ_ASSERT_NXT(a_move_out, clk, rst_n, s1_move, m_tvalid)

endmodule

// ----- dv/tb_tpdf_dither_quantizer.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_tpdf_dither_quantizer
// Self-checking testbench for the dithered sample quantizer. Directed beats
// hit the sample extremes, seed reloads and mode changes. Random images then
// run in both output modes. A local model of the xorshift dither and the
// rounding predicts every output code, and each result beat is compared with
// the oldest prediction.
// ============================================================================
module tb_tpdf_dither_quantizer
    import tdq_pkg::*;
();

    localparam int FRAC = 24;
    localparam logic [24:0] ONE_POINT_ZERO = 25'd1 << FRAC;
    localparam logic [24:0] SAMPLE_MAX = {25{1'b1}};
    localparam longint unsigned ROUND_HALF = 64'd1 << (FRAC - 1);

    // Block ports; the inputs are driven to known values from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;       // sample_value[24:0], zero pad [31:25]
    logic        s_tuser = 1'b0;     // image_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // code_value[15:0]

    // Shadow state of the quantizer.
    mode_t       mode_shadow = MODE_DITHER8;
    logic [31:0] dither_state = SEED_INIT;

    // Predicted codes, oldest first, and run statistics.
    logic [15:0] pending_codes[$];
    logic [15:0] code_want;
    int          samples_sent = 0;
    int          codes_checked = 0;
    int          mismatch_count = 0;
    int          mode_writes = 0;
    int          image_starts = 0;

    // Idling controls for the sender and the receiver.
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          stall_left = 0;

    tpdf_dither_quantizer #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #10 clk = ~clk;

    // One generator step: shifts 13 left, 17 right, 5 left.
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // Works out the code for one accepted sample and advances the dither state.
    function automatic logic [15:0] quantize_sample(input logic [24:0] val,
                                                    input logic img);
        longint unsigned lo_a;
        longint unsigned lo_b;
        longint unsigned acc;
        longint unsigned q;
        if (img)
            dither_state = SEED_INIT;
        if (mode_shadow == MODE_DITHER8)
        begin
            dither_state = xorshift32(dither_state);
            lo_a = dither_state[15:0];
            dither_state = xorshift32(dither_state);
            lo_b = dither_state[15:0];
            // The dither sum carries a +1.0 offset, so the floor stays unsigned.
            acc = longint'(val) * 255 + ((lo_a + lo_b) << (FRAC - 16)) + ROUND_HALF;
            q = acc >> FRAC;
            if (q == 0)
                return 16'd0;
            else if (q - 1 > 255)
                return 16'd255;
            else
                return 16'(q - 1);
        end
        else
        begin
            q = (longint'(val) * 65535 + ROUND_HALF) >> FRAC;
            return (q > 65535) ? 16'hFFFF : 16'(q);
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Sends one sample beat, with an occasional idle burst in front of it.
    task automatic send_sample(input logic [24:0] val, input logic img);
        int gap;
        logic [15:0] code_pred;
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, val};
        s_tuser  <= img;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        code_pred = quantize_sample(val, img);
        pending_codes = {pending_codes, code_pred};
        samples_sent++;
        if (img)
            image_starts++;
    endtask

    // Stops sending and waits until every predicted code has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_output_mode(input mode_t m);
        wait_for_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = m;
        mode_writes++;
    endtask

    // Mostly in-range samples, with some near zero, near 1.0 and above 1.0.
    function automatic logic [24:0] random_sample();
        unique case ($urandom_range(0, 9))
            0: return 25'($urandom_range(0, 255));
            1: return 25'($urandom_range(ONE_POINT_ZERO - 512, ONE_POINT_ZERO));
            2: return 25'($urandom_range(0, SAMPLE_MAX));
            default: return 25'($urandom_range(0, ONE_POINT_ZERO));
        endcase
    endfunction

    // Dithered mode straight out of reset: extremes, clamping, seed reload.
    task automatic test_dither8_extremes();
        send_sample(25'd0, 1'b1);
        send_sample(25'd0, 1'b0);
        send_sample(25'd1, 1'b0);
        send_sample(ONE_POINT_ZERO, 1'b0);
        send_sample(ONE_POINT_ZERO - 25'd1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(25'h0AA_AAAA, 1'b0);
        send_sample(25'h155_5555, 1'b0);
        send_sample(25'h080_0000, 1'b1);
        send_sample(25'h080_0000, 1'b0);
    endtask

    // Plain rounding: zero, exact half points, 1.0 and saturation.
    task automatic test_round16_extremes();
        write_output_mode(MODE_ROUND16);
        send_sample(25'd0, 1'b0);
        send_sample(25'd1, 1'b0);
        send_sample(25'h080_0000, 1'b0);
        send_sample(25'h000_0100, 1'b0);
        send_sample(ONE_POINT_ZERO, 1'b0);
        send_sample(ONE_POINT_ZERO + 25'd1, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(25'h155_5555, 1'b1);
    endtask

    // The seed reloads in 16-bit mode without advancing, and keeps its value
    // when the mode switches back in the middle of an image.
    task automatic test_seed_across_modes();
        write_output_mode(MODE_DITHER8);
        send_sample(25'h040_0000, 1'b0);
        send_sample(25'h0C0_0000, 1'b0);
        send_sample(25'h100_0000, 1'b0);
    endtask

    // Random images of random length in one mode.
    task automatic test_random_images(input mode_t m, input int count);
        write_output_mode(m);
        for (int i = 0; i < count; i++)
            send_sample(random_sample(), ($urandom_range(0, 39) == 0));
    endtask

    // Back-to-back beats with both sides always ready.
    task automatic test_full_rate(input int count);
        wait_for_drain();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_images(MODE_ROUND16, count / 2);
        test_random_images(MODE_DITHER8, count - count / 2);
    endtask

    // Receiver readiness with random stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 6);
        m_tready <= (stall_left == 0);
    end

    // Each result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_codes.size() == 0)
                note_mismatch($sformatf("code %0d with no sample pending", m_tdata));
            else
            begin
                code_want = pending_codes.pop_front();
                codes_checked++;
                if (m_tdata !== code_want)
                    note_mismatch($sformatf("code_value expected %0d, got %0d",
                                            code_want, m_tdata));
            end
        end
    end

    // Main sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_dither8_extremes();
        test_round16_extremes();
        test_seed_across_modes();
        test_random_images(MODE_DITHER8, 250);
        test_random_images(MODE_ROUND16, 150);
        test_random_images(MODE_DITHER8, 150);
        test_full_rate(150);
        wait_for_drain();
        if (pending_codes.size() != 0)
            note_mismatch($sformatf("%0d codes never arrived", pending_codes.size()));
        $display("summary: %0d samples sent, %0d codes checked, %0d image starts",
                 samples_sent, codes_checked, image_starts);
        $display("summary: %0d mode writes, %0d mismatches", mode_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("timeout: %0d codes still pending", pending_codes.size());
        $display("tb: failure");
        $finish;
    end

endmodule
